>>> hw/rtl/host_power_sequencer_defines.svh
// Assertion macros shared by the host power sequencer RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef HOST_POWER_SEQUENCER_DEFINES_SVH
`define HOST_POWER_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define HPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("host_power_sequencer: assertion failed");
// Checked on every rising edge, reset included.
`define HPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("host_power_sequencer: assertion failed");
`else
`define HPS_ASSERT(lbl, clk, rst, prop)
`define HPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/hps_pkg.sv
// Types and constants for the host power sequencer.
// No dependencies; used by hps_cfg_regs, hps_core and host_power_sequencer.
`default_nettype none

package hps_pkg;

  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned SETTLE_W = 8;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned DATA_W   = 10;

  localparam logic [INDEX_W-1:0] REG_BLINK_LIMIT  = 8'd0;
  localparam logic [INDEX_W-1:0] REG_SETTLE_TICKS = 8'd1;

  localparam logic [LIMIT_W-1:0]  BLINK_LIMIT_RST  = 10'd300;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 8'd8;

  typedef struct packed {
    logic [LIMIT_W-1:0]  blink_limit;
    logic [SETTLE_W-1:0] settle_ticks;
  } hps_cfg_t;

  typedef struct packed {
    logic               boot_failed;
    logic [PHASE_W-1:0] phase_code;
    logic               led_on;
    logic               shutdown_request;
    logic               relay_on;
  } hps_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/hps_cfg_regs.sv
// Configuration registers of the host power sequencer (blink limit, settle ticks).
// Depends on hps_pkg.
`default_nettype none

module hps_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [hps_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [hps_pkg::DATA_W-1:0]  cfg_data,
  output hps_pkg::hps_cfg_t                cfg
);

  hps_pkg::hps_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.blink_limit  <= hps_pkg::BLINK_LIMIT_RST;
      regs.settle_ticks <= hps_pkg::SETTLE_TICKS_RST;
    end else if (cfg_valid) begin
      // Writes to indexes beyond the register list are dropped.
      if (cfg_index == hps_pkg::REG_BLINK_LIMIT) begin
        regs.blink_limit <= cfg_data[hps_pkg::LIMIT_W-1:0];
      end
      if (cfg_index == hps_pkg::REG_SETTLE_TICKS) begin
        regs.settle_ticks <= cfg_data[hps_pkg::SETTLE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hps_core.sv
// Sequencer state and next-state logic: one tick is taken per asserted step.
// Depends on hps_pkg and host_power_sequencer_defines.svh.
`default_nettype none
`include "host_power_sequencer_defines.svh"

module hps_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               button_level,
  input  wire logic               host_status,
  input  wire hps_pkg::hps_cfg_t  cfg,
  output hps_pkg::hps_result_t    res
);

  typedef enum logic [hps_pkg::PHASE_W-1:0] {
    PH_OFF         = 3'd0,
    PH_BOOT        = 3'd1,
    PH_BOOT_SETTLE = 3'd2,
    PH_RUN         = 3'd3,
    PH_SHUT        = 3'd4,
    PH_SHUT_SETTLE = 3'd5
  } phase_t;

  phase_t                       phase, phase_next;
  logic                         blink_half, blink_half_next;
  logic [hps_pkg::LIMIT_W-1:0]  period_count, period_count_next;
  logic [hps_pkg::SETTLE_W-1:0] settle_count, settle_count_next;
  logic                         button_before;
  logic                         led, failed;
  logic                         restart;
  phase_t                       restart_phase;

  always_comb begin
    phase_next        = phase;
    blink_half_next   = blink_half;
    period_count_next = period_count;
    settle_count_next = settle_count;
    led               = 1'b0;
    failed            = 1'b0;
    restart           = 1'b0;
    restart_phase     = PH_OFF;

    case (phase)
      PH_BOOT: begin
        if (!blink_half) begin
          // Status is sampled only on the first tick of a blink period.
          if (host_status) begin
            restart       = 1'b1;
            restart_phase = PH_BOOT_SETTLE;
            led           = 1'b1;
          end else begin
            blink_half_next = 1'b1;
          end
        end else begin
          blink_half_next = 1'b0;
          led             = 1'b1;
          if (period_count >= cfg.blink_limit) begin
            failed        = 1'b1;
            restart       = 1'b1;
            restart_phase = PH_SHUT;
          end else begin
            period_count_next = period_count + 10'd1;
          end
        end
      end
      PH_BOOT_SETTLE: begin
        led = 1'b1;
        if (settle_count >= cfg.settle_ticks) begin
          restart       = 1'b1;
          restart_phase = PH_RUN;
        end else begin
          settle_count_next = settle_count + 8'd1;
        end
      end
      PH_RUN: begin
        led = 1'b1;
        if (button_level || !host_status) begin
          restart       = 1'b1;
          restart_phase = PH_SHUT;
        end
      end
      PH_SHUT: begin
        if (!blink_half) begin
          if (!host_status) begin
            restart       = 1'b1;
            restart_phase = PH_SHUT_SETTLE;
          end else begin
            blink_half_next = 1'b1;
            led             = 1'b1;
          end
        end else begin
          blink_half_next = 1'b0;
          if (period_count >= cfg.blink_limit) begin
            restart       = 1'b1;
            restart_phase = PH_SHUT_SETTLE;
          end else begin
            period_count_next = period_count + 10'd1;
          end
        end
      end
      PH_SHUT_SETTLE: begin
        if (settle_count >= cfg.settle_ticks) begin
          restart       = 1'b1;
          restart_phase = PH_OFF;
        end else begin
          settle_count_next = settle_count + 8'd1;
        end
      end
      default: begin
        // Off: only a rising edge of the button starts a boot.
        if (button_level && !button_before) begin
          restart       = 1'b1;
          restart_phase = PH_BOOT;
        end
      end
    endcase

    if (restart) begin
      phase_next        = restart_phase;
      blink_half_next   = 1'b0;
      period_count_next = '0;
      settle_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_OFF;
      blink_half    <= 1'b0;
      period_count  <= '0;
      settle_count  <= '0;
      button_before <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      blink_half    <= blink_half_next;
      period_count  <= period_count_next;
      settle_count  <= settle_count_next;
      button_before <= button_level;
    end
  end

  assign res.relay_on         = (phase_next != PH_OFF);
  assign res.shutdown_request = (phase_next == PH_SHUT) || (phase_next == PH_SHUT_SETTLE);
  assign res.led_on           = led;
  assign res.phase_code       = phase_next;
  assign res.boot_failed      = failed;

  `HPS_ASSERT(a_fail_from_boot, clk, rst,
    (step && res.boot_failed) |-> (phase == PH_BOOT && blink_half))
  `HPS_ASSERT(a_fail_goes_shut, clk, rst,
    (step && res.boot_failed) |=> (phase == PH_SHUT && period_count == '0))
  `HPS_ASSERT(a_half_in_wait, clk, rst,
    blink_half |-> (phase == PH_BOOT || phase == PH_SHUT))
  `HPS_ASSERT(a_settle_in_settle, clk, rst,
    (settle_count != '0) |-> (phase == PH_BOOT_SETTLE || phase == PH_SHUT_SETTLE))
  `HPS_ASSERT(a_hold_no_step, clk, rst,
    !step |=> ($stable(phase) && $stable(period_count) && $stable(settle_count)))

endmodule

`default_nettype wire

>>> hw/rtl/host_power_sequencer.sv
// Host power sequencer top level: stream ports, input and result registers.
// Depends on hps_pkg, hps_cfg_regs, hps_core and host_power_sequencer_defines.svh.
`default_nettype none
`include "host_power_sequencer_defines.svh"

// Each request is one 500 ms tick carrying the sampled button and host status
// levels; it yields exactly one result with the relay, shutdown request, LED,
// phase and boot-failure outputs as they stand after that tick. Requests are
// taken one per clock cycle while the output is not stalled: a request lands
// in the input register, the single next-state pass of hps_core evaluates it,
// and the result register presents it; a stalled result register stalls the
// input side only when both registers are full.
// Configuration writes are always ready and should be issued while idle.
module host_power_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [0] button_level, [1] host_status
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [0] relay_on, [1] shutdown_request, [2] led_on, [5:3] phase_code, [6] boot_failed
  output logic [7:0]                       m_axis_tdata,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [hps_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [hps_pkg::DATA_W-1:0]  cfg_data
);

  hps_pkg::hps_cfg_t    cfg;
  hps_pkg::hps_result_t res;
  hps_pkg::hps_result_t out_res;

  logic in_valid;
  logic in_button;
  logic in_status;
  logic out_free;
  logic step;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        m_axis_tvalid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_button <= s_axis_tdata[0];
      in_status <= s_axis_tdata[1];
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.boot_failed, out_res.phase_code,
                         out_res.led_on, out_res.shutdown_request, out_res.relay_on};

  hps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hps_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .button_level (in_button),
    .host_status  (in_status),
    .cfg          (cfg),
    .res          (res)
  );

  // A request held in the input register is never dropped while the output stalls.
  `HPS_ASSERT(a_in_kept, clk, rst, (in_valid && !out_free) |=> in_valid)
  // A request evaluated this cycle is on the output in the next.
  `HPS_ASSERT(a_step_out, clk, rst, step |=> m_axis_tvalid)
  // A result that is not taken stays on the output unchanged.
  `HPS_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

`default_nettype wire
